### rtl/core/batch_order_restorer_top_assert.svh
// assertion macros for the order restorer rtl
`ifndef BATCH_ORDER_RESTORER_TOP_ASSERT_SVH
`define BATCH_ORDER_RESTORER_TOP_ASSERT_SVH

// checked on every clock edge outside reset
`define BOR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define BOR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/core/bor_pkg.sv
// request codes, status codes and field widths of the order restorer
`default_nettype none

package bor_pkg;

    localparam int REQ_W    = 2;
    localparam int CORE_W   = 5;
    localparam int PORT_W   = 5;
    localparam int HANDLE_W = 32;
    localparam int STATUS_W = 3;
    localparam int ENTRY_W  = PORT_W + HANDLE_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_OPEN   = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_CLOSE  = 2'd2,
        REQ_DRAIN  = 2'd3
    } t_req;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_OK         = 3'd0;
    localparam t_status ST_RING_FULL  = 3'd1;
    localparam t_status ST_BATCH_FULL = 3'd2;
    localparam t_status ST_NOT_READY  = 3'd3;
    localparam t_status ST_NO_BATCH   = 3'd4;

endpackage

`default_nettype wire

### rtl/core/bor_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module bor_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                           i_wr_data,
    input  wire logic                                       i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // read data holds while no read is issued
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/batch_order_restorer_top.sv
// order-restoring buffer for packet batches of parallel worker cores
// Each worker core opens a batch slot (slots are claimed in arrival order), appends
// (port, handle) packets to it and closes it; a drain item releases the oldest slot
// only when it is closed, as a run of one result per packet with the last flagged.
// Every other item gives a single status result. Slot state (ready bit and fill count)
// and the packets live in two single-port-read rams; a slot's state is written when it
// is claimed, so there is no clearing pass after reset. Each item first reads its slot's
// state; close and append write it back and rejected items give their status. An open
// also marks the core's previous slot closed, then writes the new slot in a second write
// step before the next item is taken. A drain reads the packets from the packet ram, one
// result per cycle unless the output stalls, which holds an item until its result loads.
// One item is worked on at a time; the next is taken once the previous item's last
// result has entered the output register, where it may wait while the next item starts.
`default_nettype none

`include "batch_order_restorer_top_assert.svh"

module batch_order_restorer_top #(
    parameter int RING_SLOTS     = 128,
    parameter int BATCH_CAPACITY = 32,
    parameter int CORE_COUNT     = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [bor_pkg::REQ_W-1:0]     i_req_type,
    input  wire logic [bor_pkg::CORE_W-1:0]    i_core_id,
    input  wire logic [bor_pkg::PORT_W-1:0]    i_dest_port,
    input  wire logic [bor_pkg::HANDLE_W-1:0]  i_pkt_handle,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [bor_pkg::PORT_W-1:0]    o_out_port,
    output logic      [bor_pkg::HANDLE_W-1:0]  o_out_handle,
    output logic                               o_out_has_packet,
    output logic                               o_out_last,
    output logic      [bor_pkg::STATUS_W-1:0]  o_status
);

    import bor_pkg::*;

    localparam int SW = $clog2(RING_SLOTS);
    localparam int FW = $clog2(BATCH_CAPACITY + 1);
    localparam int IW = (BATCH_CAPACITY > 1) ? $clog2(BATCH_CAPACITY) : 1;
    localparam int CW = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;
    localparam int OW = $clog2(RING_SLOTS + 1);
    localparam int MW = FW + 1;
    localparam int SD = RING_SLOTS * (2 ** IW);
    localparam int SAW = SW + IW;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_LOOK  = 4'b0010,
        S_OPEN2 = 4'b0100,
        S_DRAIN = 4'b1000
    } t_state;

    function automatic logic [SW-1:0] f_next(input logic [SW-1:0] s);
        return (s == SW'(RING_SLOTS - 1)) ? '0 : s + 1'b1;
    endfunction

    // control state
    t_state                r_state, n_state;
    logic [SW-1:0]         r_head, n_head;
    logic [SW-1:0]         r_tail, n_tail;
    logic [OW-1:0]         r_occ, n_occ;
    logic [CORE_COUNT-1:0] r_core_open, n_core_open;
    logic [FW-1:0]         r_cnt, n_cnt;
    logic [FW-1:0]         r_n, n_n;
    logic                  r_out_valid;

    // item and per-core payload
    t_req                  r_req;
    logic [CORE_W-1:0]     r_core;
    logic                  r_core_ok;
    logic [PORT_W-1:0]     r_port;
    logic [HANDLE_W-1:0]   r_handle;
    logic [SW-1:0]         r_slot;
    logic [SW-1:0]         r_core_slot [CORE_COUNT];
    logic [PORT_W-1:0]     r_out_port;
    logic [HANDLE_W-1:0]   r_out_handle;
    logic                  r_out_has;
    logic                  r_out_last;
    t_status               r_out_status;

    logic                  in_acc;
    logic                  in_core_ok;
    logic [SW-1:0]         in_cslot;
    logic [CW-1:0]         core_idx;
    logic                  core_is_open;
    logic                  out_free;
    logic                  drain_last;
    logic [FW-1:0]         cnt_inc;

    logic                  meta_we, meta_re;
    logic [SW-1:0]         meta_wa, meta_ra;
    logic [MW-1:0]         meta_wd, meta_rd;
    logic                  m_ready;
    logic [FW-1:0]         m_fill;

    logic                  st_we, st_re;
    logic [SAW-1:0]        st_wa, st_ra;
    logic [ENTRY_W-1:0]    st_wd, st_rd;

    logic                  cs_we;
    logic                  lo_load;
    logic [PORT_W-1:0]     lo_port;
    logic [HANDLE_W-1:0]   lo_handle;
    logic                  lo_has;
    logic                  lo_last;
    t_status               lo_status;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign in_core_ok  = (32'(i_core_id) < CORE_COUNT);
    assign in_cslot    = in_core_ok ? r_core_slot[CW'(i_core_id)] : '0;

    assign core_idx     = CW'(r_core);
    assign core_is_open = r_core_ok && r_core_open[core_idx];
    assign out_free     = !r_out_valid || !i_out_stall;
    assign m_ready      = meta_rd[FW];
    assign m_fill       = meta_rd[FW-1:0];
    assign cnt_inc      = r_cnt + FW'(1);
    assign drain_last   = (cnt_inc == r_n);

    bor_ram #(
        .WIDTH (MW),
        .DEPTH (RING_SLOTS)
    ) u_meta_ram (
        .i_clk     (i_clk),
        .i_wr_en   (meta_we),
        .i_wr_addr (meta_wa),
        .i_wr_data (meta_wd),
        .i_rd_en   (meta_re),
        .i_rd_addr (meta_ra),
        .o_rd_data (meta_rd)
    );

    bor_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SD)
    ) u_pkt_ram (
        .i_clk     (i_clk),
        .i_wr_en   (st_we),
        .i_wr_addr (st_wa),
        .i_wr_data (st_wd),
        .i_rd_en   (st_re),
        .i_rd_addr (st_ra),
        .o_rd_data (st_rd)
    );

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_occ       = r_occ;
        n_core_open = r_core_open;
        n_cnt       = r_cnt;
        n_n         = r_n;
        meta_we     = 1'b0;
        meta_wa     = r_slot;
        meta_wd     = '0;
        meta_re     = 1'b0;
        meta_ra     = (i_req_type == REQ_DRAIN) ? r_head : in_cslot;
        st_we       = 1'b0;
        st_wa       = {r_slot, IW'(m_fill)};
        st_wd       = {r_port, r_handle};
        st_re       = 1'b0;
        st_ra       = {r_head, IW'(cnt_inc)};
        cs_we       = 1'b0;
        lo_load     = 1'b0;
        lo_port     = '0;
        lo_handle   = '0;
        lo_has      = 1'b0;
        lo_last     = 1'b1;
        lo_status   = ST_OK;

        case (r_state)
            S_IDLE: begin
                meta_re = in_acc;
                if (in_acc) begin
                    n_state = S_LOOK;
                end
            end

            S_LOOK: begin
                case (r_req)
                    REQ_DRAIN: begin
                        if (r_occ == '0 || !m_ready) begin
                            if (out_free) begin
                                lo_load   = 1'b1;
                                lo_status = ST_NOT_READY;
                                n_state   = S_IDLE;
                            end
                        end else if (m_fill == '0) begin
                            // closed but empty batch: one empty result, slot freed
                            if (out_free) begin
                                lo_load = 1'b1;
                                meta_we = 1'b1;
                                meta_wa = r_head;
                                n_head  = f_next(r_head);
                                n_occ   = r_occ - 1'b1;
                                n_state = S_IDLE;
                            end
                        end else begin
                            st_re   = 1'b1;
                            st_ra   = {r_head, IW'(0)};
                            n_cnt   = '0;
                            n_n     = m_fill;
                            n_state = S_DRAIN;
                        end
                    end
                    REQ_OPEN: begin
                        if (out_free) begin
                            lo_load = 1'b1;
                            n_state = S_IDLE;
                            if (!r_core_ok) begin
                                lo_status = ST_NO_BATCH;
                            end else if (r_occ == OW'(RING_SLOTS)) begin
                                lo_status = ST_RING_FULL;
                            end else begin
                                // reopening closes the previous batch first
                                meta_we = core_is_open;
                                meta_wd = {1'b1, m_fill};
                                n_state = S_OPEN2;
                            end
                        end
                    end
                    REQ_APPEND: begin
                        if (out_free) begin
                            lo_load = 1'b1;
                            n_state = S_IDLE;
                            if (!core_is_open) begin
                                lo_status = ST_NO_BATCH;
                            end else if (32'(m_fill) >= BATCH_CAPACITY) begin
                                lo_status = ST_BATCH_FULL;
                            end else begin
                                st_we   = 1'b1;
                                meta_we = 1'b1;
                                meta_wd = {m_ready, m_fill + FW'(1)};
                            end
                        end
                    end
                    REQ_CLOSE: begin
                        if (out_free) begin
                            lo_load = 1'b1;
                            n_state = S_IDLE;
                            if (!core_is_open) begin
                                lo_status = ST_NO_BATCH;
                            end else begin
                                meta_we               = 1'b1;
                                meta_wd               = {1'b1, m_fill};
                                n_core_open[core_idx] = 1'b0;
                            end
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_OPEN2: begin
                meta_we               = 1'b1;
                meta_wa               = r_tail;
                cs_we                 = 1'b1;
                n_core_open[core_idx] = 1'b1;
                n_tail                = f_next(r_tail);
                n_occ                 = r_occ + 1'b1;
                n_state               = S_IDLE;
            end

            S_DRAIN: begin
                // packet ram data holds while the output is stalled
                if (out_free) begin
                    lo_load   = 1'b1;
                    lo_port   = st_rd[ENTRY_W-1:HANDLE_W];
                    lo_handle = st_rd[HANDLE_W-1:0];
                    lo_has    = 1'b1;
                    lo_last   = drain_last;
                    if (drain_last) begin
                        meta_we = 1'b1;
                        meta_wa = r_head;
                        n_head  = f_next(r_head);
                        n_occ   = r_occ - 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        st_re = 1'b1;
                        n_cnt = cnt_inc;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_core_open <= '0;
            r_cnt       <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_occ       <= n_occ;
            r_core_open <= n_core_open;
            r_cnt       <= n_cnt;
            r_n         <= n_n;
            if (lo_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req     <= t_req'(i_req_type);
            r_core    <= i_core_id;
            r_core_ok <= in_core_ok;
            r_port    <= i_dest_port;
            r_handle  <= i_pkt_handle;
            r_slot    <= in_cslot;
        end
        if (cs_we) begin
            r_core_slot[core_idx] <= r_tail;
        end
        if (lo_load) begin
            r_out_port   <= lo_port;
            r_out_handle <= lo_handle;
            r_out_has    <= lo_has;
            r_out_last   <= lo_last;
            r_out_status <= lo_status;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_port       = r_out_port;
    assign o_out_handle     = r_out_handle;
    assign o_out_has_packet = r_out_has;
    assign o_out_last       = r_out_last;
    assign o_status         = r_out_status;

    `BOR_ASSERT(a_state_onehot, $onehot(r_state), "state register is not one-hot")
    `BOR_ASSERT(a_occ_bound, (r_occ <= OW'(RING_SLOTS)), "occupancy beyond ring size")
    `BOR_ASSERT(a_ring_ptrs, (r_head == r_tail) |-> (r_occ == '0 || r_occ == OW'(RING_SLOTS)), "ring pointers off")
    `BOR_ASSERT(a_drain_cnt, (r_state == S_DRAIN) |-> (r_cnt < r_n), "drain index past batch fill")
    `BOR_ASSERT(a_open_room, (r_state == S_OPEN2) |-> (r_occ != OW'(RING_SLOTS)), "slot claimed on a full ring")

endmodule

`default_nettype wire
